### hw/rtl/crc32_append_and_check_assert.svh
// assertion macros for the crc32 append and check block
// used by the port checker; expects aclk and aresetn in the scope of use
`ifndef CRC32_APPEND_AND_CHECK_ASSERT_SVH
`define CRC32_APPEND_AND_CHECK_ASSERT_SVH

// same-cycle implication, held off during reset
`define CRCAC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define CRCAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/crcac_pkg.sv
// shared types and constants for the crc32 append and check block
// no dependencies; imported by every module of the block
package crcac_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_POLY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd2;

    localparam logic [31:0] POLY_RESET  = 32'hEDB8_8320;
    localparam logic [31:0] START_RESET = 32'hFFFF_FFFF;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    // trailing crc delay line and byte counter
    localparam int              TAIL_LEN  = 4;
    localparam int              SEEN_W    = 3;
    localparam logic [SEEN_W-1:0] SEEN_FULL = 3'd4;

    // command queue between front and back
    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // back end phase: echo, then four crc bytes
    localparam int              PHASE_W    = 3;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd4;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_CRC     = 2'd1,
        KIND_VERDICT = 2'd2
    } crcac_kind_t;

    // back end commands
    typedef enum logic [1:0] {
        OP_ECHO     = 2'd0,
        OP_ECHO_CRC = 2'd1,
        OP_VERDICT  = 2'd2
    } crcac_op_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } crcac_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] item_kind;
        logic       out_last;
        logic       crc_ok;
        logic       too_short;
    } crcac_out_t;

    typedef struct packed {
        crcac_op_t   op;
        logic [7:0]  data_byte;
        logic [31:0] crc_out;
        logic        crc_ok;
        logic        too_short;
    } crcac_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } crcac_qstat_t;

endpackage

### hw/rtl/crcac_fifo.sv
// command queue between the classify front and the result back end
// depends on crcac_pkg
module crcac_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  crcac_pkg::crcac_cmd_t   wdata,
    input  logic                    pop,
    output crcac_pkg::crcac_cmd_t   rdata,
    output crcac_pkg::crcac_qstat_t stat
);
    import crcac_pkg::*;

    crcac_cmd_t        mem_reg [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QIDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    // status and head
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/crcac_front.sv
// front end: configuration registers, running crc, delay line, classification
// depends on crcac_pkg; feeds crcac_fifo
module crcac_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [crcac_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [crcac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  crcac_pkg::crcac_in_t              s_data,
    input  crcac_pkg::crcac_qstat_t           q_stat,
    output logic                              q_push,
    output crcac_pkg::crcac_cmd_t             q_wdata
);
    import crcac_pkg::*;

    logic [31:0]       poly_reg, start_reg;
    logic              mode_reg;
    logic [31:0]       crc_reg, crc_next;
    logic [SEEN_W-1:0] seen_reg, seen_next, seen_after;
    logic [7:0]        tail_reg  [TAIL_LEN];
    logic [7:0]        tail_next [TAIL_LEN];
    logic              accept, full_line, feed_en, last;
    logic [7:0]        feed_byte;
    logic [31:0]       crc_base, crc_fed, crc_inv, got;

    // reflected crc, one byte through eight conditional shifts
    function automatic logic [31:0] crc_byte_step(input logic [31:0] crc,
                                                  input logic [7:0]  b,
                                                  input logic [31:0] poly);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    // ready only out of reset and with room in the queue
    assign s_ready = aresetn && !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign last    = s_data.end_of_packet;

    // configuration writes, unlisted index ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg  <= POLY_RESET;
            start_reg <= START_RESET;
            mode_reg  <= MODE_APPEND;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_POLY:  poly_reg  <= cfg_wdata[31:0];
                REG_START: start_reg <= cfg_wdata[31:0];
                REG_MODE:  mode_reg  <= cfg_wdata[0];
                default:   ;
            endcase
        end
    end

    // crc update: check mode feeds the byte leaving the delay line
    assign full_line = (seen_reg == SEEN_FULL);
    assign crc_base  = (seen_reg == '0) ? start_reg : crc_reg;
    assign feed_byte = (mode_reg == MODE_CHECK) ? tail_reg[0] : s_data.data_byte;
    assign feed_en   = (mode_reg == MODE_APPEND) || full_line;
    assign crc_fed   = crc_byte_step(crc_base, feed_byte, poly_reg);
    assign crc_next  = feed_en ? crc_fed : crc_base;
    assign crc_inv   = ~crc_next;

    // delay line: fill, then shift once full
    always_comb begin
        tail_next = tail_reg;
        if (full_line) begin
            for (int i = 0; i < TAIL_LEN - 1; i++) begin
                tail_next[i] = tail_reg[i + 1];
            end
            tail_next[TAIL_LEN - 1] = s_data.data_byte;
        end else begin
            tail_next[seen_reg[1:0]] = s_data.data_byte;
        end
    end

    assign seen_after = full_line ? seen_reg : seen_reg + 1'b1;
    assign seen_next  = last ? '0 : seen_after;
    assign got        = {tail_next[3], tail_next[2], tail_next[1], tail_next[0]};

    // classify the request for the back end
    always_comb begin
        q_wdata.op        = last ? OP_ECHO_CRC : OP_ECHO;
        q_wdata.data_byte = s_data.data_byte;
        q_wdata.crc_out   = crc_inv;
        q_wdata.too_short = 1'b0;
        q_wdata.crc_ok    = 1'b0;
        if (mode_reg == MODE_CHECK) begin
            q_wdata.op        = OP_VERDICT;
            q_wdata.too_short = (seen_after != SEEN_FULL);
            q_wdata.crc_ok    = (seen_after == SEEN_FULL) && (got == crc_inv);
        end
    end

    assign q_push = accept && ((mode_reg == MODE_APPEND) || last);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
            crc_reg  <= START_RESET;
        end else if (accept) begin
            seen_reg <= seen_next;
            crc_reg  <= crc_next;
        end
    end

    // delay line storage
    always_ff @(posedge aclk) begin
        if (accept) begin
            tail_reg <= tail_next;
        end
    end

endmodule

### hw/rtl/crcac_back.sv
// back end: expands queued commands into result items behind an output register
// depends on crcac_pkg; drains crcac_fifo
module crcac_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  crcac_pkg::crcac_qstat_t q_stat,
    input  crcac_pkg::crcac_cmd_t   q_rdata,
    output logic                    q_pop,
    output logic                    m_valid,
    input  logic                    m_ready,
    output crcac_pkg::crcac_out_t   m_data
);
    import crcac_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic               m_valid_reg, m_valid_next;
    crcac_out_t         m_data_reg, item;
    logic               load, take, last_phase;
    logic [1:0]         crc_idx;
    logic [PHASE_W-1:0] phase_dec;

    assign load      = !m_valid_reg || m_ready;
    assign take      = load && !q_stat.empty;
    assign phase_dec = phase_reg - 1'b1;
    assign crc_idx   = phase_dec[1:0];

    // build the next result from the queue head
    always_comb begin
        item.out_byte  = q_rdata.data_byte;
        item.item_kind = KIND_DATA;
        item.out_last  = 1'b0;
        item.crc_ok    = 1'b0;
        item.too_short = 1'b0;
        last_phase     = 1'b1;
        unique case (q_rdata.op)
            OP_ECHO: ;
            OP_ECHO_CRC: begin
                last_phase = (phase_reg == PHASE_LAST);
                if (phase_reg != '0) begin
                    item.out_byte  = q_rdata.crc_out[{crc_idx, 3'b000} +: 8];
                    item.item_kind = KIND_CRC;
                    item.out_last  = last_phase;
                end
            end
            OP_VERDICT: begin
                item.out_byte  = '0;
                item.item_kind = KIND_VERDICT;
                item.out_last  = 1'b1;
                item.crc_ok    = q_rdata.crc_ok;
                item.too_short = q_rdata.too_short;
            end
            default: ;
        endcase
    end

    // phase and output valid
    always_comb begin
        phase_next   = phase_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = !q_stat.empty;
        end
        if (take) begin
            phase_next = last_phase ? '0 : phase_reg + 1'b1;
        end
    end

    assign q_pop = take && last_phase;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        if (take) begin
            m_data_reg <= item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hw/rtl/crc32_append_and_check.sv
// crc32 append and check, top level: front end, command queue, back end
// path: the first result of a request is written to the command queue when the request
//   is accepted, then loaded into the output register of the back end
// throughput: one byte per cycle while the four-entry queue has room; a final append
//   byte gives an echo and four crc bytes, the queue rides out part, then input stalls
// reset: synchronous active-low aresetn clears control state and loads the
//   register reset values; no clearing pass, ready as soon as reset is released
module crc32_append_and_check (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [crcac_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [crcac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  crcac_pkg::crcac_in_t              s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output crcac_pkg::crcac_out_t             m_data
);
    import crcac_pkg::*;

    crcac_qstat_t q_stat;
    crcac_cmd_t   q_wdata, q_rdata;
    logic         q_push, q_pop;

    // classify and run the crc
    crcac_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    // decoupling queue
    crcac_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    // result expansion
    crcac_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .q_rdata (q_rdata),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

### hw/rtl/crcac_check.sv
// port checker for the crc32 append and check result channel, bound to the top
// depends on crcac_pkg and crc32_append_and_check_assert.svh
`include "crc32_append_and_check_assert.svh"

module crcac_check (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input crcac_pkg::crcac_out_t m_data
);
    import crcac_pkg::*;

    // stalled result holds
    `CRCAC_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped or changed while stalled")

    // a verdict closes the packet and carries no byte
    `CRCAC_ASSERT_IMPL(a_verdict, m_valid && (m_data.item_kind == KIND_VERDICT), m_data.out_last && (m_data.out_byte == 8'd0), "verdict not last or byte nonzero")

    // echoed data never ends a packet and carries no flags
    `CRCAC_ASSERT_IMPL(a_data, m_valid && (m_data.item_kind == KIND_DATA), !m_data.out_last && !m_data.crc_ok && !m_data.too_short, "echoed byte marked last or flagged")

    // a short packet can never match
    `CRCAC_ASSERT_IMPL(a_flags, m_valid, !(m_data.crc_ok && m_data.too_short), "match and too short together")

endmodule

bind crc32_append_and_check crcac_check u_check (.*);

### tb/tb.sv
// testbench for crc32_append_and_check: byte requests in, echo/crc/verdict results out
// depends on crcac_pkg and the crc32_append_and_check top level; needs nothing else
`timescale 1ns / 1ps

module tb;

    import crcac_pkg::*;

    // index with no register behind it, writes are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned HOLD_CYCLES    = 60;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_PRINTS     = 40;

    typedef logic [7:0] byte_q_t[$];

    // predicts the result stream of the block and holds what is still owed
    class crc_scoreboard;
        logic [31:0] poly;
        logic [31:0] start_val;
        logic        mode_check;
        logic [31:0] crc_acc;
        logic [7:0]  tail [TAIL_LEN];
        int unsigned seen;
        crcac_out_t  owed_q[$];

        int unsigned mismatches;
        int unsigned results_checked;
        int unsigned append_packets;
        int unsigned check_packets;
        int unsigned match_verdicts;
        int unsigned short_verdicts;

        function new();
            poly       = POLY_RESET;
            start_val  = START_RESET;
            mode_check = MODE_APPEND;
            crc_acc    = START_RESET;
            foreach (tail[i]) tail[i] = 8'h00;
            seen = 0;
            mismatches = 0;
            results_checked = 0;
            append_packets = 0;
            check_packets = 0;
            match_verdicts = 0;
            short_verdicts = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            unique case (idx)
                REG_POLY:  poly = val;
                REG_START: start_val = val;
                REG_MODE:  mode_check = val[0];
                default: ;
            endcase
        endfunction

        // one byte through the reflected crc, table entry built bit by bit
        function logic [31:0] fold_byte(logic [31:0] c, logic [7:0] b);
            logic [31:0] t;
            int k;
            t = {24'h0, c[7:0] ^ b};
            for (k = 0; k < 8; k++) begin
                if (t[0]) t = (t >> 1) ^ poly;
                else t = t >> 1;
            end
            return (c >> 8) ^ t;
        endfunction

        // inverted crc of a payload under the current setting
        function logic [31:0] packet_crc(byte_q_t bytes);
            logic [31:0] c;
            c = start_val;
            foreach (bytes[i]) c = fold_byte(c, bytes[i]);
            return ~c;
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        function void note_request(crcac_in_t req);
            crcac_out_t  r;
            logic [31:0] fin;
            logic [31:0] trailer;
            int          i;
            if (seen == 0) crc_acc = start_val;

            // delay line: fill, then shift; check mode feeds the byte that drops out
            if (seen >= TAIL_LEN) begin
                if (mode_check == MODE_CHECK) crc_acc = fold_byte(crc_acc, tail[0]);
                tail[0] = tail[1];
                tail[1] = tail[2];
                tail[2] = tail[3];
                tail[3] = req.data_byte;
            end else begin
                tail[seen] = req.data_byte;
                seen++;
            end

            if (mode_check == MODE_APPEND) begin
                crc_acc = fold_byte(crc_acc, req.data_byte);
                r = '0;
                r.out_byte  = req.data_byte;
                r.item_kind = KIND_DATA;
                owed_q = {owed_q, r};
                if (req.end_of_packet) begin
                    fin = ~crc_acc;
                    for (i = 0; i < 4; i++) begin
                        r = '0;
                        r.out_byte  = fin[8*i +: 8];
                        r.item_kind = KIND_CRC;
                        r.out_last  = (i == 3);
                        owed_q = {owed_q, r};
                    end
                    append_packets++;
                end
            end else if (req.end_of_packet) begin
                r = '0;
                r.item_kind = KIND_VERDICT;
                r.out_last  = 1'b1;
                if (seen < TAIL_LEN) begin
                    r.too_short = 1'b1;
                    short_verdicts++;
                end else begin
                    trailer  = {tail[3], tail[2], tail[1], tail[0]};
                    r.crc_ok = (trailer == ~crc_acc);
                    if (r.crc_ok) match_verdicts++;
                end
                owed_q = {owed_q, r};
                check_packets++;
            end

            if (req.end_of_packet) seen = 0;
        endfunction

        task report(string msg);
            if (mismatches < MAX_PRINTS) $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(crcac_out_t got);
            crcac_out_t want;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected result byte %02h kind %0d",
                                 got.out_byte, got.item_kind));
                return;
            end
            want = owed_q.pop_front();
            results_checked++;
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
            if (got.item_kind !== want.item_kind)
                report($sformatf("item_kind %0d, want %0d", got.item_kind, want.item_kind));
            if (got.out_last !== want.out_last)
                report($sformatf("out_last %b, want %b", got.out_last, want.out_last));
            if (got.crc_ok !== want.crc_ok)
                report($sformatf("crc_ok %b, want %b", got.crc_ok, want.crc_ok));
            if (got.too_short !== want.too_short)
                report($sformatf("too_short %b, want %b", got.too_short, want.too_short));
        endtask
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    crcac_in_t             s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    crcac_out_t            m_data;

    crc_scoreboard sb = new();

    int unsigned burst_left   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_cycles = 0;
    int unsigned hold_count   = 0;
    bit          hold_request = 1'b0;

    crc32_append_and_check u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // no-progress watchdog and input back-pressure count
    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready) stall_cycles++;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request or result moved for %0d cycles", quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // receiver: changing stall styles, plus a long hold-off on demand
    initial begin
        int unsigned ready_style;
        int unsigned style_left;
        ready_style = 0;
        style_left  = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                hold_count++;
            end else begin
                if (style_left == 0) begin
                    ready_style = $urandom_range(0, 3);
                    style_left  = $urandom_range(10, 60);
                end
                style_left--;
                unique case (ready_style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    // offer one request in bursts with random gaps; returns after acceptance
    task automatic send_request(input crcac_in_t req);
        int unsigned gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(30, 80);
            else burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    task automatic send_packet(input byte_q_t bytes, input bit with_end);
        crcac_in_t req;
        int        i;
        for (i = 0; i < bytes.size(); i++) begin
            req.data_byte     = bytes[i];
            req.end_of_packet = with_end && (i == bytes.size() - 1);
            send_request(req);
        end
    endtask

    // stop offering, wait for every owed result, then let the pipe empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    // random packets under the current setting until n_items bytes are sent
    task automatic run_random_phase(input int unsigned n_items);
        byte_q_t     pkt;
        int unsigned done_items;
        int unsigned len;
        int unsigned pick;
        int unsigned pos;
        logic [31:0] crc;
        int          i;
        done_items = 0;
        while (done_items < n_items) begin
            pkt.delete();
            if (sb.mode_check == MODE_APPEND) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
                repeat (len) pkt = {pkt, 8'($urandom_range(0, 255))};
            end else begin
                pick = $urandom_range(0, 9);
                if (pick <= 7) begin
                    // payload followed by its own crc, sometimes with one bit flipped
                    len = $urandom_range(0, 6);
                    repeat (len) pkt = {pkt, 8'($urandom_range(0, 255))};
                    crc = sb.packet_crc(pkt);
                    for (i = 0; i < 4; i++) pkt = {pkt, crc[8*i +: 8]};
                    if (pick == 7) begin
                        pos = $urandom_range(0, pkt.size() - 1);
                        pkt[pos] = pkt[pos] ^ (8'h01 << $urandom_range(0, 7));
                    end
                end else if (pick == 8) begin
                    len = $urandom_range(1, 3);
                    repeat (len) pkt = {pkt, 8'($urandom_range(0, 255))};
                end else begin
                    len = $urandom_range(4, 10);
                    repeat (len) pkt = {pkt, 8'($urandom_range(0, 255))};
                end
            end
            send_packet(pkt, 1'b1);
            done_items += pkt.size();
        end
    endtask

    initial begin
        byte_q_t     pkt;
        logic [31:0] crc;
        int          i;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // append mode at reset values: one-byte packets at both extremes, then four bytes
        pkt = {8'h00};
        send_packet(pkt, 1'b1);
        pkt = {8'hFF};
        send_packet(pkt, 1'b1);
        pkt = {8'h31, 8'h32, 8'h33, 8'h34};
        send_packet(pkt, 1'b1);
        settle();

        // check mode: short packets of one and three bytes
        write_reg(REG_MODE, 32'(MODE_CHECK));
        pkt = {8'h5A};
        send_packet(pkt, 1'b1);
        pkt = {8'hFF, 8'h00, 8'hFF};
        send_packet(pkt, 1'b1);
        // four bytes only: trailer of an empty payload
        pkt = {8'h00, 8'h00, 8'h00, 8'h00};
        send_packet(pkt, 1'b1);
        // one payload byte with a correct trailer
        pkt = {8'hA5};
        crc = sb.packet_crc(pkt);
        for (i = 0; i < 4; i++) pkt = {pkt, crc[8*i +: 8]};
        send_packet(pkt, 1'b1);

        // mode switched to append in the middle of a packet
        pkt = {8'h11, 8'h22};
        send_packet(pkt, 1'b0);
        settle();
        write_reg(REG_MODE, 32'(MODE_APPEND));
        pkt = {8'h33, 8'h44, 8'h55};
        send_packet(pkt, 1'b1);

        // random phases; the first two include a long receiver hold-off
        hold_request = 1'b1;
        run_random_phase(40);
        settle();
        write_reg(REG_MODE, 32'(MODE_CHECK));
        hold_request = 1'b1;
        run_random_phase(40);

        settle();
        write_reg(REG_POLY, 32'h0000_0000);
        write_reg(REG_START, 32'h0000_0000);
        write_reg(REG_MODE, 32'(MODE_APPEND));
        run_random_phase(30);

        settle();
        write_reg(REG_POLY, 32'hFFFF_FFFF);
        write_reg(REG_START, 32'hFFFF_FFFF);
        write_reg(REG_MODE, 32'(MODE_CHECK));
        run_random_phase(40);

        settle();
        write_reg(REG_POLY, 32'h82F6_3B78);
        write_reg(REG_START, 32'h0000_0000);
        run_random_phase(40);

        settle();
        write_reg(REG_POLY, $urandom);
        write_reg(REG_START, $urandom);
        write_reg(REG_MODE, 32'(MODE_APPEND));
        write_reg(REG_SPARE, $urandom);
        run_random_phase(40);

        settle();
        write_reg(REG_MODE, 32'(MODE_CHECK));
        run_random_phase(40);

        settle();
        write_reg(REG_POLY, POLY_RESET);
        write_reg(REG_START, START_RESET);
        run_random_phase(20);
        settle();
        write_reg(REG_MODE, 32'(MODE_APPEND));
        run_random_phase(20);

        settle();
        $display("covered %0d append and %0d check packets, %0d results compared",
                 sb.append_packets, sb.check_packets, sb.results_checked);
        $display("%0d crc matches, %0d short verdicts, %0d hold-offs, %0d input stall cycles",
                 sb.match_verdicts, sb.short_verdicts, hold_count, stall_cycles);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/crcac_pkg.sv
hw/rtl/crcac_fifo.sv
hw/rtl/crcac_front.sv
hw/rtl/crcac_back.sv
hw/rtl/crc32_append_and_check.sv
hw/rtl/crcac_check.sv
tb/tb.sv
